>>> hdl/bde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and codes for the bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int BDE_CAPACITY = 16;
    localparam int WORD_W       = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [WORD_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] word;
        logic                     last;
    } rsp_word_t;

    typedef struct packed {
        logic       wr_front;
        logic       wr_back;
        logic       rd_front;
        logic       rd_back;
        logic       dump_start;
        logic       dump_step;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_from_mem;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/bounded_deque_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed words over a circular store.
// ----------------------------------------------------------------------------
// Push: one word per cycle while the response register is free; the response is valid in the cycle after acceptance.
// Pop: a registered store read, then the response load; one pop at a time.
// Dump: one store read per emitted word, front to back.
// Empty or full responses need no store read. Undefined opcodes are dropped.
// Reset (rst_n low, asynchronous) empties the queue; store contents persist.
// ----------------------------------------------------------------------------
module bounded_deque_engine
    import bde_pkg::*;
#(
    parameter int CAPACITY = BDE_CAPACITY
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_word_t cmd_data,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_word_t  rsp_data
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    bde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .opcode    (cmd_data.opcode),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    bde_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (cmd_data.value),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
`default_nettype wire

>>> hdl/bde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_ctrl
// Sequencer: decodes each command word, steers the datapath through pops
// and dumps.
// ----------------------------------------------------------------------------
module bde_ctrl
    import bde_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire logic [2:0] opcode,
    input  wire dp_sts_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cmd_ready = (state_reg == S_IDLE) && sts.out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && sts.out_free)
                begin
                    case (opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = sts.full ? ST_FULL : ST_OK;
                            cmd.wr_front   = !sts.full && (opcode == OP_PUSH_FRONT);
                            cmd.wr_back    = !sts.full && (opcode == OP_PUSH_BACK);
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_front = (opcode == OP_POP_FRONT);
                                cmd.rd_back  = (opcode == OP_POP_BACK);
                                state_next   = S_POP_WAIT;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.dump_start = 1'b1;
                                state_next     = S_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_last     = 1'b1;
                    cmd.out_status   = ST_OK;
                    cmd.out_from_mem = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_last     = sts.dump_last;
                    cmd.out_status   = ST_OK;
                    cmd.out_from_mem = 1'b1;
                    if (sts.dump_last)
                        state_next = S_IDLE;
                    else
                        cmd.dump_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

>>> hdl/bde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bde_datapath
// Circular word store, front pointer, fill count, dump index and the
// response register.
// ----------------------------------------------------------------------------
module bde_datapath
    import bde_pkg::*;
#(
    parameter int CAPACITY = BDE_CAPACITY
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic signed [WORD_W-1:0] value,
    input  wire dp_cmd_t cmd,
    output dp_sts_t    sts,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_word_t  rsp_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]   CAP_SUM  = (CNT_W + 1)'(CAPACITY);

    logic [WORD_W-1:0] mem [CAPACITY];

    logic [IDX_W-1:0] front_reg;
    logic [IDX_W-1:0] front_next;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             rsp_valid_reg;
    rsp_word_t        rsp_data_reg;
    logic [WORD_W-1:0] rdata_reg;

    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    function automatic logic [IDX_W-1:0] wrap_pos(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
        if (sum >= CAP_SUM)
            sum = sum - CAP_SUM;
        return sum[IDX_W-1:0];
    endfunction

    assign sts.full      = (occ_reg == CAP_CNT);
    assign sts.empty     = (occ_reg == '0);
    assign sts.dump_last = ((idx_reg + CNT_W'(1)) == occ_reg);
    assign sts.out_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        if (cmd.wr_front)
        begin
            front_next = (front_reg == '0) ? LAST_POS : front_reg - IDX_W'(1);
            wr_en      = 1'b1;
            wr_addr    = front_next;
            occ_next   = occ_reg + CNT_W'(1);
        end
        else if (cmd.wr_back)
        begin
            wr_en    = 1'b1;
            wr_addr  = wrap_pos(front_reg, occ_reg);
            occ_next = occ_reg + CNT_W'(1);
        end
        else if (cmd.rd_front)
        begin
            rd_en      = 1'b1;
            rd_addr    = front_reg;
            front_next = wrap_pos(front_reg, CNT_W'(1));
            occ_next   = occ_reg - CNT_W'(1);
        end
        else if (cmd.rd_back)
        begin
            rd_en    = 1'b1;
            rd_addr  = wrap_pos(front_reg, occ_reg - CNT_W'(1));
            occ_next = occ_reg - CNT_W'(1);
        end
        else if (cmd.dump_start)
        begin
            rd_en    = 1'b1;
            rd_addr  = front_reg;
            idx_next = '0;
        end
        else if (cmd.dump_step)
        begin
            rd_en    = 1'b1;
            idx_next = idx_reg + CNT_W'(1);
            rd_addr  = wrap_pos(front_reg, idx_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= value;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            occ_reg   <= occ_next;
            idx_reg   <= idx_next;
            if (cmd.out_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_data_reg.status <= cmd.out_status;
            rsp_data_reg.word   <= cmd.out_from_mem ? $signed(rdata_reg) : '0;
            rsp_data_reg.last   <= cmd.out_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
`default_nettype wire
